// ----- rtl/vlmf_pkg.sv -----
// Package for the variable-length message FIFO: widths, codes, payload structs
// and controller/datapath command and status types. No dependencies.
package vlmf_pkg;

	localparam int BufDepth   = 4096;
	localparam int IndexDepth = 64;
	localparam int BufAw      = $clog2(BufDepth);
	localparam int IdxAw      = $clog2(IndexDepth);
	localparam int RingW      = BufAw + 1;
	localparam int MaxW       = IdxAw + 1;
	localparam int CfgW       = 13;
	localparam int LenW       = 12;

	localparam logic CFG_RING_SIZE    = 1'b0;
	localparam logic CFG_MAX_MESSAGES = 1'b1;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_DATA_FULL = 3'd2,
		ST_IDX_FULL  = 3'd3,
		ST_DROPPED   = 3'd4,
		ST_EMPTY_MSG = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FULL_NONE = 2'd0,
		FULL_IDX  = 2'd1,
		FULL_DATA = 2'd2
	} full_t;

	typedef enum logic [1:0] {
		WM_IDLE     = 2'd0,
		WM_WRITING  = 2'd1,
		WM_DROPPING = 2'd2
	} wmode_t;

	typedef enum logic [1:0] {
		CS_IDLE = 2'd0,
		CS_GET  = 2'd1,
		CS_OUT  = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic [1:0]      operation;
		logic [7:0]      data_byte;
		logic [LenW-1:0] message_length;
		logic            last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_byte;
		logic       end_of_message;
		logic [5:0] message_count;
		logic [1:0] full_state;
		logic       queue_empty;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;      // apply item (put, clear, none, or get when no fetch needed)
		logic get_fetch; // start a get: index memory read this cycle
		logic get_byte;  // byte memory read this cycle, address from fetched state
		logic get_done;  // finish a get using fetched data
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_fetch; // pending get needs memory read
	} dp_stat_t;

endpackage

// ----- rtl/vlmf_ctrl.sv -----
// Controller state machine for the message FIFO: handshake and sequencing.
// Depends on vlmf_pkg.
module vlmf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  vlmf_pkg::dp_stat_t   stat,
	output vlmf_pkg::dp_cmd_t    cmd,
	output logic                 load_out
);
	vlmf_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vlmf_pkg::CS_IDLE: begin
				if (in_valid && stat.need_fetch) state_d = vlmf_pkg::CS_GET;
			end
			vlmf_pkg::CS_GET: state_d = vlmf_pkg::CS_OUT;
			vlmf_pkg::CS_OUT: if (out_free) state_d = vlmf_pkg::CS_IDLE;
			default: state_d = vlmf_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			vlmf_pkg::CS_IDLE: begin
				if (in_valid && stat.need_fetch) begin
					cmd.get_fetch = 1'b1;
				end else begin
					in_ready = out_free;
					cmd.exec = in_valid && out_free;
					load_out = in_valid && out_free;
				end
			end
			vlmf_pkg::CS_GET: begin
				cmd.get_byte = 1'b1;
			end
			vlmf_pkg::CS_OUT: begin
				in_ready = out_free;
				cmd.get_done = out_free;
				load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vlmf_pkg::CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free) else $error("result overwritten");
	a_get_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.get_fetch |=> state_q == vlmf_pkg::CS_GET) else $error("fetch sequence");
	a_get_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vlmf_pkg::CS_GET |=> state_q == vlmf_pkg::CS_OUT) else $error("get seq");
endmodule

// ----- rtl/vlmf_datapath.sv -----
// Datapath for the message FIFO: byte store, index store, pointers and result.
// Depends on vlmf_pkg.
module vlmf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [vlmf_pkg::CfgW-1:0]     cfg_data,
	input  vlmf_pkg::in_item_t            item,
	input  vlmf_pkg::dp_cmd_t             cmd,
	input  logic                          load_out,
	output vlmf_pkg::dp_stat_t            stat,
	output vlmf_pkg::out_item_t           result
);
	localparam int AW = vlmf_pkg::BufAw;
	localparam int IW = vlmf_pkg::IdxAw;
	localparam int RW = vlmf_pkg::RingW;
	localparam int MW = vlmf_pkg::MaxW;
	localparam int LW = vlmf_pkg::LenW;

	logic [7:0]      byte_mem [vlmf_pkg::BufDepth];
	logic [2*AW-1:0] idx_mem  [vlmf_pkg::IndexDepth];

	logic [RW-1:0] ring_q;
	logic [MW-1:0] maxm_q;
	logic [IW-1:0] ihead_q, itail_q;
	logic [AW-1:0] dhead_q, dtail_q, wcur_q, rcur_q, rend_q;
	logic [LW-1:0] wrem_q;
	vlmf_pkg::wmode_t wmode_q;
	logic ract_q;

	logic [7:0]      rbyte_q;
	logic [2*AW-1:0] rdesc_q;
	logic            fetch_idx_q;

	// next-state values
	logic [IW-1:0] ihead_d, itail_d;
	logic [AW-1:0] dhead_d, dtail_d, wcur_d, rcur_d, rend_d;
	logic [LW-1:0] wrem_d;
	vlmf_pkg::wmode_t wmode_d;
	logic ract_d;
	logic          bwe, iwe;
	logic [AW-1:0] baddr;
	logic [IW-1:0] iaddr;
	logic [2*AW-1:0] idata;
	vlmf_pkg::status_t st;
	logic [7:0] rb;
	logic eom;

	logic [IW-1:0] ihead_inc, itail_inc;
	logic [AW-1:0] wcur_inc, rcur_inc, beg_v, end_v;
	logic ifull;
	logic [LW:0] hl;
	logic [LW:0] hl_mod;
	logic drej;
	logic lenz, len_gt1;

	function automatic logic [IW-1:0] iinc(input logic [IW-1:0] v, input logic [MW-1:0] m);
		logic [MW-1:0] s;
		s = {1'b0, v} + MW'(1);
		return (s == m) ? '0 : s[IW-1:0];
	endfunction

	function automatic logic [AW-1:0] binc(input logic [AW-1:0] v, input logic [RW-1:0] r);
		logic [RW-1:0] s;
		s = {1'b0, v} + RW'(1);
		return (s == r) ? '0 : s[AW-1:0];
	endfunction

	assign ihead_inc = iinc(ihead_q, maxm_q);
	assign itail_inc = iinc(itail_q, maxm_q);
	assign wcur_inc  = binc(wcur_q, ring_q);
	assign rcur_inc  = binc(rcur_q, ring_q);
	assign ifull     = (ihead_inc == itail_q);
	assign lenz      = (item.message_length == '0);
	assign len_gt1   = (item.message_length > LW'(1));
	assign hl        = {1'b0, dhead_q} + {1'b0, item.message_length};
	assign hl_mod    = (hl >= (LW+1)'(ring_q)) ? hl - (LW+1)'(ring_q) : hl;

	always_comb begin
		drej = 1'b0;
		if ({1'b0, item.message_length} >= ring_q) drej = 1'b1;
		else if (dhead_q >= dtail_q) begin
			if (hl > (LW+1)'(ring_q) && hl_mod >= (LW+1)'(dtail_q)) drej = 1'b1;
		end else if (hl >= (LW+1)'(dtail_q)) drej = 1'b1;
	end

	// descriptor as fetched; begin/end already inside ring
	assign beg_v = rdesc_q[2*AW-1:AW];
	assign end_v = rdesc_q[AW-1:0];

	assign stat.need_fetch = (vlmf_pkg::op_t'(item.operation) == vlmf_pkg::OP_GET)
		&& (ract_q || (ihead_q != itail_q));

	always_comb begin
		ihead_d = ihead_q; itail_d = itail_q;
		dhead_d = dhead_q; dtail_d = dtail_q;
		wcur_d = wcur_q; rcur_d = rcur_q; rend_d = rend_q;
		wrem_d = wrem_q; wmode_d = wmode_q; ract_d = ract_q;
		bwe = 1'b0; iwe = 1'b0;
		baddr = wcur_q; iaddr = ihead_q; idata = '0;
		st = vlmf_pkg::ST_OK; rb = '0; eom = 1'b0;
		if (cmd.get_done) begin
			if (!fetch_idx_q) begin
				rb = rbyte_q;
				if (rcur_inc == rend_q) begin
					eom = 1'b1; itail_d = itail_inc; dtail_d = rend_q; ract_d = 1'b0;
				end else rcur_d = rcur_inc;
			end else if (beg_v == end_v) begin
				st = vlmf_pkg::ST_EMPTY_MSG; eom = 1'b1;
				itail_d = itail_inc; dtail_d = end_v; ract_d = 1'b0;
			end else begin
				rb = rbyte_q;
				if (binc(beg_v, ring_q) == end_v) begin
					eom = 1'b1; itail_d = itail_inc; dtail_d = end_v; ract_d = 1'b0;
				end else begin
					rcur_d = binc(beg_v, ring_q); rend_d = end_v; ract_d = 1'b1;
				end
			end
		end else if (cmd.exec) begin
			unique case (vlmf_pkg::op_t'(item.operation))
				vlmf_pkg::OP_PUT: begin
					if (wmode_q == vlmf_pkg::WM_DROPPING) begin
						st = vlmf_pkg::ST_DROPPED;
						wrem_d = wrem_q - LW'(1);
						if (wrem_d == '0 || item.last_byte) wmode_d = vlmf_pkg::WM_IDLE;
					end else if (wmode_q == vlmf_pkg::WM_WRITING) begin
						bwe = 1'b1; baddr = wcur_q; wcur_d = wcur_inc;
						wrem_d = wrem_q - LW'(1);
						if (wrem_d == '0 || item.last_byte) begin
							iwe = 1'b1; idata = {dhead_q, wcur_inc};
							ihead_d = ihead_inc; dhead_d = wcur_inc;
							wmode_d = vlmf_pkg::WM_IDLE;
						end
					end else if (drej || ifull) begin
						st = drej ? vlmf_pkg::ST_DATA_FULL : vlmf_pkg::ST_IDX_FULL;
						if (len_gt1 && !item.last_byte) begin
							wmode_d = vlmf_pkg::WM_DROPPING;
							wrem_d = item.message_length - LW'(1);
						end
					end else if (lenz) begin
						iwe = 1'b1; idata = {dhead_q, dhead_q}; ihead_d = ihead_inc;
					end else begin
						// opening byte written at data head
						bwe = 1'b1; baddr = dhead_q;
						wrem_d = item.message_length - LW'(1);
						if (wrem_d == '0 || item.last_byte) begin
							iwe = 1'b1; idata = {dhead_q, binc(dhead_q, ring_q)};
							ihead_d = ihead_inc; dhead_d = binc(dhead_q, ring_q);
							wcur_d = binc(dhead_q, ring_q);
						end else begin
							wcur_d = binc(dhead_q, ring_q);
							wmode_d = vlmf_pkg::WM_WRITING;
						end
					end
				end
				vlmf_pkg::OP_GET: st = vlmf_pkg::ST_EMPTY; // fetch path handles non-empty
				vlmf_pkg::OP_CLEAR: begin
					ihead_d = '0; itail_d = '0; ract_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// result fields
	logic [MW-1:0] cnt;
	vlmf_pkg::full_t fs;
	always_comb begin
		cnt = (ihead_d >= itail_d) ? MW'(ihead_d) - MW'(itail_d)
			: MW'(ihead_d) + maxm_q - MW'(itail_d);
		if (iinc(ihead_d, maxm_q) == itail_d) fs = vlmf_pkg::FULL_IDX;
		else if (dhead_d < dtail_d && ({1'b0, dhead_d} + RW'(1)) >= {1'b0, dtail_d})
			fs = vlmf_pkg::FULL_DATA;
		else fs = vlmf_pkg::FULL_NONE;
	end

	// memories: descriptor read first, then byte at cursor or descriptor begin
	always_ff @(posedge clk) begin
		if (bwe) byte_mem[baddr] <= item.data_byte;
		if (iwe) idx_mem[iaddr] <= idata;
		if (cmd.get_fetch) begin
			rdesc_q <= idx_mem[itail_q];
			fetch_idx_q <= !ract_q;
		end
		if (cmd.get_byte) rbyte_q <= byte_mem[fetch_idx_q ? beg_v : rcur_q];
		if (load_out) begin
			result.status <= st;
			result.read_byte <= rb;
			result.end_of_message <= eom;
			result.message_count <= 6'(cnt);
			result.full_state <= fs;
			result.queue_empty <= (ihead_d == itail_d);
		end
	end

	logic [RW-1:0] ring_w;
	logic [MW-1:0] maxm_w;
	always_comb begin
		ring_w = cfg_data[RW-1:0];
		if (ring_w < RW'(2)) ring_w = RW'(2);
		if (ring_w > RW'(vlmf_pkg::BufDepth)) ring_w = RW'(vlmf_pkg::BufDepth);
		maxm_w = cfg_data[MW-1:0];
		if (maxm_w < MW'(2)) maxm_w = MW'(2);
		if (maxm_w > MW'(vlmf_pkg::IndexDepth)) maxm_w = MW'(vlmf_pkg::IndexDepth);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RW'(vlmf_pkg::BufDepth);
			maxm_q <= MW'(vlmf_pkg::IndexDepth);
			ihead_q <= '0; itail_q <= '0; dhead_q <= '0; dtail_q <= '0;
			wcur_q <= '0; rcur_q <= '0; rend_q <= '0; wrem_q <= '0;
			wmode_q <= vlmf_pkg::WM_IDLE; ract_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == vlmf_pkg::CFG_RING_SIZE) ring_q <= ring_w;
			else maxm_q <= maxm_w;
			ihead_q <= '0; itail_q <= '0; dhead_q <= '0; dtail_q <= '0;
			wcur_q <= '0; rcur_q <= '0; rend_q <= '0; wrem_q <= '0;
			wmode_q <= vlmf_pkg::WM_IDLE; ract_q <= 1'b0;
		end else begin
			ihead_q <= ihead_d; itail_q <= itail_d; dhead_q <= dhead_d; dtail_q <= dtail_d;
			wcur_q <= wcur_d; rcur_q <= rcur_d; rend_q <= rend_d; wrem_q <= wrem_d;
			wmode_q <= wmode_d; ract_q <= ract_d;
		end
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		MW'(ihead_q) < maxm_q && MW'(itail_q) < maxm_q) else $error("index pointer range");
	a_no_dual: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.get_done)) else $error("two commands");
	a_dhead_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, dhead_q} < ring_q) else $error("data head range");
endmodule

// ----- rtl/variable_length_message_fifo.sv -----
// Top level of the variable-length message FIFO.
// Depends on vlmf_pkg, vlmf_ctrl and vlmf_datapath.
//
// A FIFO of variable-length messages over one item stream. Each input item is
// a put (one byte; the first byte of a message carries its declared length and
// checks data and index space), a get (one byte of the oldest message), a clear
// of the index pointers, or nothing; each item yields exactly one result with
// status, byte, end-of-message flag, message count and full/empty state.
// Bytes sit in a 4096-byte store and descriptors in a 64-entry index ring,
// both synchronous RAMs. Put, clear and idle items and gets on an empty queue
// are applied in the idle state; a get on a non-empty queue (an empty message
// included) reads the index memory in the idle state, the byte memory in
// the get state, and forms the result and takes the item in the output state
// once the result register, which separates the output, is free; a new item
// is taken while the previous result waits if that register frees that cycle.
// Configuration writes (ring_size, max_messages) clamp the value and reset all
// pointers; write them only while idle.
module variable_length_message_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  vlmf_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output vlmf_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [vlmf_pkg::CfgW-1:0]         cfg_data
);
	vlmf_pkg::dp_cmd_t  cmd;
	vlmf_pkg::dp_stat_t stat;
	logic load_out;

	vlmf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd, .load_out
	);

	vlmf_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.item(in_item), .cmd, .load_out, .stat, .result(out_item)
	);
endmodule

// ----- tb/sv/variable_length_message_fifo_tb.sv -----
// Testbench for variable_length_message_fifo: random and directed put/get/clear
// traffic against an in-bench message FIFO predictor. Depends on vlmf_pkg and the DUT.
`timescale 1ns / 100ps

module variable_length_message_fifo_tb;

	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	vlmf_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	vlmf_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = vlmf_pkg::CFG_RING_SIZE;
	logic [vlmf_pkg::CfgW-1:0] cfg_data = '0;

	variable_length_message_fifo u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// items waiting to be offered, results the predictor expects
	vlmf_pkg::in_item_t pending_items[$];
	vlmf_pkg::out_item_t expected_results[$];
	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_cycles = 0;
	logic hold_arm = 1'b0;
	int cycle_count = 0;

	// ---------------------------------------------------------------
	// Predictor state: mirrors the block's pointers and stores
	// ---------------------------------------------------------------
	int unsigned m_ring, m_maxmsg;
	logic [7:0] m_bytes[vlmf_pkg::BufDepth];
	int unsigned m_beg[vlmf_pkg::IndexDepth], m_end[vlmf_pkg::IndexDepth];
	int unsigned m_ihead, m_itail, m_dhead, m_dtail;
	int unsigned m_wcur, m_wrem, m_rcur, m_rend;
	vlmf_pkg::wmode_t m_wmode;
	bit m_ractive;

	function automatic void fifo_reset_ptrs();
		m_ihead = 0; m_itail = 0; m_dhead = 0; m_dtail = 0;
		m_wcur = 0; m_wrem = 0; m_wmode = vlmf_pkg::WM_IDLE;
		m_rcur = 0; m_rend = 0; m_ractive = 0;
	endfunction

	function automatic bit idx_full();
		return (m_ihead + 1) % m_maxmsg == m_itail;
	endfunction

	function automatic bit data_rejects(int unsigned len);
		if (len >= m_ring) return 1;
		if (m_dhead >= m_dtail && m_dhead + len > m_ring
		    && (m_dhead + len) % m_ring >= m_dtail) return 1;
		if (m_dhead < m_dtail && m_dhead + len >= m_dtail) return 1;
		return 0;
	endfunction

	function automatic void commit_msg(int unsigned e);
		m_beg[m_ihead] = m_dhead;
		m_end[m_ihead] = e;
		m_ihead = (m_ihead + 1) % m_maxmsg;
		m_dhead = e;
	endfunction

	function automatic void retire_msg(int unsigned e);
		m_itail = (m_itail + 1) % m_maxmsg;
		m_dtail = e;
		m_ractive = 0;
	endfunction

	function automatic vlmf_pkg::status_t put_byte(logic [7:0] b, int unsigned len, bit last);
		if (m_wmode == vlmf_pkg::WM_IDLE) begin
			// opening byte: data space first, then index space
			if (data_rejects(len) || idx_full()) begin
				vlmf_pkg::status_t st;
				st = data_rejects(len) ? vlmf_pkg::ST_DATA_FULL : vlmf_pkg::ST_IDX_FULL;
				if (len > 1 && !last) begin
					m_wmode = vlmf_pkg::WM_DROPPING;
					m_wrem = len - 1;
				end
				return st;
			end
			if (len == 0) begin
				commit_msg(m_dhead);
				return vlmf_pkg::ST_OK;
			end
			m_wcur = m_dhead;
			m_wrem = len;
			m_wmode = vlmf_pkg::WM_WRITING;
		end
		if (m_wmode == vlmf_pkg::WM_DROPPING) begin
			m_wrem = (m_wrem - 1) & 12'hFFF;
			if (m_wrem == 0 || last) m_wmode = vlmf_pkg::WM_IDLE;
			return vlmf_pkg::ST_DROPPED;
		end
		m_bytes[m_wcur] = b;
		m_wcur = (m_wcur + 1) % m_ring;
		m_wrem = (m_wrem - 1) & 12'hFFF;
		if (m_wrem == 0 || last) begin
			commit_msg(m_wcur);
			m_wmode = vlmf_pkg::WM_IDLE;
		end
		return vlmf_pkg::ST_OK;
	endfunction

	function automatic vlmf_pkg::out_item_t fifo_predict(vlmf_pkg::in_item_t it);
		vlmf_pkg::out_item_t r;
		int unsigned b, e;
		r = '0;
		case (vlmf_pkg::op_t'(it.operation))
			vlmf_pkg::OP_PUT: r.status = put_byte(it.data_byte, it.message_length, it.last_byte);
			vlmf_pkg::OP_GET: begin
				if (!m_ractive) begin
					if (m_ihead == m_itail) r.status = vlmf_pkg::ST_EMPTY;
					else begin
						b = m_beg[m_itail];
						e = m_end[m_itail];
						if (b == e) begin
							// zero-length message is removed on its get
							r.status = vlmf_pkg::ST_EMPTY_MSG;
							r.end_of_message = 1'b1;
							retire_msg(e);
						end else begin
							m_rcur = b % m_ring;
							m_rend = e % m_ring;
							m_ractive = 1;
						end
					end
				end
				if (m_ractive) begin
					r.status = vlmf_pkg::ST_OK;
					r.read_byte = m_bytes[m_rcur];
					m_rcur = (m_rcur + 1) % m_ring;
					if (m_rcur == m_rend) begin
						r.end_of_message = 1'b1;
						retire_msg(m_rend);
					end
				end
			end
			vlmf_pkg::OP_CLEAR: begin
				// index pointers only; data pointers and a put in flight stay
				m_ihead = 0;
				m_itail = 0;
				m_ractive = 0;
			end
			default: ;
		endcase
		r.message_count = 6'((m_ihead >= m_itail) ? m_ihead - m_itail
		                                          : m_ihead + m_maxmsg - m_itail);
		if (idx_full()) r.full_state = vlmf_pkg::FULL_IDX;
		else if (m_dhead < m_dtail && m_dhead + 1 >= m_dtail)
			r.full_state = vlmf_pkg::FULL_DATA;
		else r.full_state = vlmf_pkg::FULL_NONE;
		r.queue_empty = (m_ihead == m_itail);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers queued items, predicts on each accepted one
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(fifo_predict(in_item));
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
		else if (hold_arm) hold_cycles <= 400;
	end

	function automatic void check_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, out_item);
					errors++;
				end else begin
					vlmf_pkg::out_item_t e;
					e = expected_results.pop_front();
					check_field("status", e.status, out_item.status);
					check_field("read_byte", e.read_byte, out_item.read_byte);
					check_field("end_of_message", e.end_of_message, out_item.end_of_message);
					check_field("message_count", e.message_count, out_item.message_count);
					check_field("full_state", e.full_state, out_item.full_state);
					check_field("queue_empty", e.queue_empty, out_item.queue_empty);
				end
			end
			out_ready <= (hold_cycles > 0) ? 1'b0 : ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void queue_item(vlmf_pkg::op_t op, logic [7:0] b,
		logic [vlmf_pkg::LenW-1:0] len, bit last);
		vlmf_pkg::in_item_t it;
		it.operation = op;
		it.data_byte = b;
		it.message_length = len;
		it.last_byte = last;
		pending_items.push_back(it);
	endfunction

	// one message: opening byte carries len; may end early on last_byte
	function automatic int queue_message(int unsigned len, bit early);
		int unsigned n;
		n = (len == 0) ? 1 : (early ? $urandom_range(len, 1) : len);
		if (n > 12 && early) n = $urandom_range(12, 1);
		for (int unsigned i = 0; i < n; i++)
			queue_item(vlmf_pkg::OP_PUT, 8'($urandom),
				(i == 0) ? len[vlmf_pkg::LenW-1:0] : vlmf_pkg::LenW'($urandom),
				(i == n - 1) && (early || $urandom_range(1)));
		return n;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		int unsigned v;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= vlmf_pkg::CfgW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		// predictor follows the clamp and the pointer reset
		if (idx == vlmf_pkg::CFG_RING_SIZE) begin
			v = val & 13'h1FFF;
			m_ring = (v < 2) ? 2 : (v > vlmf_pkg::BufDepth ? vlmf_pkg::BufDepth : v);
		end else begin
			v = val & 7'h7F;
			m_maxmsg = (v < 2) ? 2 : (v > vlmf_pkg::IndexDepth ? vlmf_pkg::IndexDepth : v);
		end
		fifo_reset_ptrs();
	endtask

	task automatic queue_random(int count);
		int n;
		int r;
		int unsigned len;
		n = 0;
		while (n < count) begin
			r = $urandom_range(99);
			if (r < 45) begin
				len = ($urandom_range(99) < 8) ? $urandom_range(4095) : $urandom_range(24);
				n += queue_message(len, $urandom_range(99) < 25 || len > 24);
			end else if (r < 85) begin
				r = $urandom_range(30, 1);
				repeat (r) queue_item(vlmf_pkg::OP_GET, 8'($urandom),
					vlmf_pkg::LenW'($urandom), 1'($urandom));
				n += r;
			end else if (r < 90) begin
				queue_item(vlmf_pkg::OP_CLEAR, 8'($urandom), vlmf_pkg::LenW'($urandom),
					1'($urandom));
				n++;
			end else if (r < 94) begin
				queue_item(vlmf_pkg::OP_NONE, 8'($urandom), vlmf_pkg::LenW'($urandom),
					1'($urandom));
				n++;
			end else begin
				// noise: any operation with any fields
				queue_item(vlmf_pkg::op_t'($urandom_range(3)), 8'($urandom),
					vlmf_pkg::LenW'($urandom), 1'($urandom));
				n++;
			end
		end
	endtask

	int ring_vals[6] = '{4096, 16, 2, 8191, 100, 0};
	int max_vals[6]  = '{64, 4, 2, 127, 9, 1};
	int idle_snd[4]  = '{0, 51, 0, 32};
	int idle_rcv[4]  = '{0, 0, 51, 32};

	initial begin
		m_ring = vlmf_pkg::BufDepth;
		m_maxmsg = vlmf_pkg::IndexDepth;
		for (int i = 0; i < vlmf_pkg::BufDepth; i++) m_bytes[i] = '0;
		for (int i = 0; i < vlmf_pkg::IndexDepth; i++) begin
			m_beg[i] = 0;
			m_end[i] = 0;
		end
		fifo_reset_ptrs();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(vlmf_pkg::CFG_RING_SIZE, ring_vals[ph]);
			write_reg(vlmf_pkg::CFG_MAX_MESSAGES, max_vals[ph]);
			@(negedge clk);
			snd_idle_pct = idle_snd[ph % 4];
			rcv_stall_pct = idle_rcv[ph % 4];
			if (ph == 0) begin
				// empty get, idle, clear, empty message and its get
				queue_item(vlmf_pkg::OP_GET, 8'hFF, 12'hFFF, 1'b1);
				queue_item(vlmf_pkg::OP_NONE, 8'h00, 12'h000, 1'b0);
				queue_item(vlmf_pkg::OP_CLEAR, 8'hFF, 12'hFFF, 1'b1);
				queue_item(vlmf_pkg::OP_PUT, 8'hA5, 12'h000, 1'b0);
				queue_item(vlmf_pkg::OP_GET, 8'h00, 12'h000, 1'b0);
				// full-count message with extreme bytes
				queue_item(vlmf_pkg::OP_PUT, 8'h00, 12'd3, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'hFF, 12'hFFF, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'h5A, 12'h000, 1'b0);
				// byte past the count opens a new message, which ends early
				queue_item(vlmf_pkg::OP_PUT, 8'h81, 12'd5, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'h7E, 12'd0, 1'b1);
				repeat (5) queue_item(vlmf_pkg::OP_GET, 8'h00, 12'h000, 1'b0);
				// near-maximum declared length, ended early by last_byte
				queue_item(vlmf_pkg::OP_PUT, 8'h11, 12'hFFF, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'h22, 12'h000, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'h33, 12'h000, 1'b1);
				// clear abandons a get in progress
				queue_item(vlmf_pkg::OP_PUT, 8'h44, 12'd2, 1'b0);
				queue_item(vlmf_pkg::OP_PUT, 8'h55, 12'd2, 1'b0);
				queue_item(vlmf_pkg::OP_GET, 8'h00, 12'h000, 1'b0);
				queue_item(vlmf_pkg::OP_CLEAR, 8'h00, 12'h000, 1'b0);
				queue_item(vlmf_pkg::OP_GET, 8'h00, 12'h000, 1'b0);
				wait_drained();
				// flood while the receiver holds off
				hold_arm = 1'b1;
				@(negedge clk);
				hold_arm = 1'b0;
			end
			queue_random(170);
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
